// ===== rtl/core/best_fit_block_allocator_macros.svh =====
// Assertion macros used by the checker of the allocator.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFBA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfba: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfba: next-cycle check failed");

`endif

// ===== rtl/core/bfba_pkg.sv =====
package bfba_pkg;

    // Field widths of the item payloads and of a block header size.
    localparam int CFG_W  = 13;
    localparam int SIZE_W = 16;

    // Lower region limit and the region size after reset.
    localparam int REGION_MIN = 64;
    localparam int CFG_RESET  = 4096;

    // Operation codes of an input item.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [CFG_W-1:0]  request_size;
        logic [CFG_W-1:0]  free_offset;
        logic              free_is_null;
    } t_in_item;

    typedef struct packed {
        logic              success;
        logic [CFG_W-1:0]  payload_offset;
    } t_out_item;

    // One block header as stored in the header memory.
    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    // Status of the sequencer as seen by the top level.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_ctrl_stat;

endpackage

// ===== rtl/core/best_fit_block_allocator.sv =====
// Best-fit allocator over a byte region kept as a chain of headed blocks. The
// headers live in one memory indexed by header offset, read one per cycle. An
// allocate item walks the chain until an exact fit or its end, then splits
// the best block when needed; a free item walks to the block freed, or to the
// end of the chain, and reads its successor; a null free walks no chain. Each
// item gives one result item. After reset or a region write the block lays
// down the first header before it takes an item. The region register is
// written only while no item is in flight; a result waiting in the output
// register does not keep the next item from starting.
module best_fit_block_allocator #(
    parameter int REGION_BYTES = 4096,
    parameter int HEADER_BYTES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bfba_pkg::t_in_item          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bfba_pkg::t_out_item         o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bfba_pkg::CFG_W-1:0]  i_cfg_data
);
    import bfba_pkg::*;

    localparam int AW = $clog2(REGION_BYTES);

    t_ctrl_stat      stat;
    t_out_item       res;
    logic            item_we;
    logic            cfg_we;
    logic            res_take;
    logic [AW-1:0]   rd_addr;
    t_hdr            rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_hdr            wr_data;
    logic            r_out_valid;
    t_out_item       r_out;

    // Handshakes: the region write has priority over a new item.
    assign o_cfg_ready = stat.idle;
    assign o_in_stall  = !stat.idle || i_cfg_valid;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign item_we     = i_in_valid && !o_in_stall;
    assign res_take    = stat.res_valid && (!r_out_valid || !i_out_stall);

    bfba_ctrl #(
        .REGION_BYTES (REGION_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .AW           (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item_we  (item_we),
        .i_item     (i_in),
        .i_res_take (res_take),
        .o_stat     (stat),
        .o_res      (res),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    bfba_hdr_ram #(
        .DEPTH (REGION_BYTES),
        .AW    (AW)
    ) u_hdr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register holds a finished item until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/bfba_hdr_ram.sv =====
module bfba_hdr_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  bfba_pkg::t_hdr  i_wr_data,
    input  logic [AW-1:0]   i_rd_addr,
    output bfba_pkg::t_hdr  o_rd_data
);
    import bfba_pkg::*;

    t_hdr r_mem [DEPTH];
    t_hdr r_rd_data;

    // Simple dual-port memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/bfba_ctrl.sv =====
module bfba_ctrl #(
    parameter int REGION_BYTES = 4096,
    parameter int HEADER_BYTES = 4,
    parameter int AW           = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bfba_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_item_we,
    input  bfba_pkg::t_in_item            i_item,
    input  logic                          i_res_take,
    output bfba_pkg::t_ctrl_stat          o_stat,
    output bfba_pkg::t_out_item           o_res,
    output logic [AW-1:0]                 o_rd_addr,
    input  bfba_pkg::t_hdr                i_rd_data,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output bfba_pkg::t_hdr                o_wr_data
);
    import bfba_pkg::*;

    // Width that holds the region size itself, and width of a header walk sum.
    localparam int PW = $clog2(REGION_BYTES + 1);
    localparam int SW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
    localparam int FW = SIZE_W + 1;

    typedef enum logic [5:0] {
        S_INIT     = 6'b000001,
        S_IDLE     = 6'b000010,
        S_WALK     = 6'b000100,
        S_FREE_NXT = 6'b001000,
        S_SPLIT    = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    // Saturate a region size to the range REGION_MIN to REGION_BYTES.
    function automatic logic [PW-1:0] clamp_region(input logic [CFG_W-1:0] v);
        logic [SW-1:0] w;
        w = SW'(v);
        if (w < SW'(REGION_MIN)) begin
            return PW'(REGION_MIN);
        end else if (w > SW'(REGION_BYTES)) begin
            return PW'(REGION_BYTES);
        end else begin
            return PW'(w);
        end
    endfunction

    t_state            r_state, n_state;
    logic [PW-1:0]     r_eff, n_eff;
    logic              r_op, n_op;
    logic [CFG_W-1:0]  r_req, n_req;
    logic [CFG_W-1:0]  r_off, n_off;
    logic [SW-1:0]     r_h, n_h;
    logic [SW-1:0]     r_n, n_n;
    logic              r_have, n_have;
    logic [AW-1:0]     r_best, n_best;
    logic [SIZE_W-1:0] r_best_size, n_best_size;
    logic [SIZE_W-1:0] r_hsize, n_hsize;
    logic [AW-1:0]     r_nh, n_nh;
    t_out_item         r_res, n_res;

    logic [SW-1:0]     h_next;
    logic              h_live;
    logic              n_live;
    logic              blk_free;
    logic              exact;
    logic              fits;
    logic              better;
    logic [FW-1:0]     req_plus_h;
    logic [SIZE_W-1:0] rest;
    logic [SW-1:0]     split_hdr;
    logic [SIZE_W-1:0] merged;

    // Header arithmetic on the word that the memory just returned.
    assign h_next     = r_h + SW'(HEADER_BYTES) + SW'(i_rd_data.size);
    assign h_live     = r_h < SW'(r_eff);
    assign n_live     = r_n < SW'(r_eff);
    assign blk_free   = !i_rd_data.used;
    assign exact      = blk_free && (i_rd_data.size == SIZE_W'(r_req));
    assign req_plus_h = FW'(r_req) + FW'(HEADER_BYTES);
    assign fits       = blk_free && (req_plus_h < FW'(i_rd_data.size));
    assign better     = !r_have || (i_rd_data.size < r_best_size);
    assign rest       = r_best_size - SIZE_W'(req_plus_h);
    assign split_hdr  = SW'(r_best) + SW'(HEADER_BYTES) + SW'(rest);
    assign merged     = r_hsize + SIZE_W'(HEADER_BYTES) + i_rd_data.size;

    // Sequencer: one header is examined per cycle while walking the chain.
    always_comb begin
        n_state     = r_state;
        n_eff       = r_eff;
        n_op        = r_op;
        n_req       = r_req;
        n_off       = r_off;
        n_h         = r_h;
        n_n         = r_n;
        n_have      = r_have;
        n_best      = r_best;
        n_best_size = r_best_size;
        n_hsize     = r_hsize;
        n_nh        = r_nh;
        n_res       = r_res;
        o_rd_addr   = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_h[AW-1:0];
        o_wr_data   = '0;

        unique case (r_state)
            S_INIT: begin
                // Rebuild the chain as one free block spanning the region.
                o_wr_en        = 1'b1;
                o_wr_addr      = '0;
                o_wr_data.used = 1'b0;
                o_wr_data.size = SIZE_W'(r_eff - PW'(HEADER_BYTES));
                n_state        = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_eff   = clamp_region(i_cfg_data);
                    n_state = S_INIT;
                end else if (i_item_we) begin
                    n_op   = i_item.opcode;
                    n_req  = i_item.request_size;
                    n_off  = i_item.free_offset;
                    n_h    = '0;
                    n_have = 1'b0;
                    if (i_item.opcode == OP_FREE && i_item.free_is_null) begin
                        n_res.success        = 1'b1;
                        n_res.payload_offset = '0;
                        n_state              = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (!h_live) begin
                    // End of chain: split the best candidate or report failure.
                    if (r_op == OP_ALLOC && r_have) begin
                        o_wr_en        = 1'b1;
                        o_wr_addr      = r_best;
                        o_wr_data.used = 1'b0;
                        o_wr_data.size = rest;
                        n_nh           = split_hdr[AW-1:0];
                        n_state        = S_SPLIT;
                    end else begin
                        n_res.success        = 1'b0;
                        n_res.payload_offset = '0;
                        n_state              = S_DONE;
                    end
                end else if (r_op == OP_ALLOC) begin
                    if (exact) begin
                        o_wr_en              = 1'b1;
                        o_wr_data.used       = 1'b1;
                        o_wr_data.size       = i_rd_data.size;
                        n_res.success        = 1'b1;
                        n_res.payload_offset = CFG_W'(r_h + SW'(HEADER_BYTES));
                        n_state              = S_DONE;
                    end else begin
                        if (fits && better) begin
                            n_have      = 1'b1;
                            n_best      = r_h[AW-1:0];
                            n_best_size = i_rd_data.size;
                        end
                        n_h       = h_next;
                        o_rd_addr = h_next[AW-1:0];
                    end
                end else begin
                    if (r_h + SW'(HEADER_BYTES) == SW'(r_off)) begin
                        // Found the block; fetch its successor for a merge.
                        n_hsize   = i_rd_data.size;
                        n_n       = h_next;
                        o_rd_addr = h_next[AW-1:0];
                        n_state   = S_FREE_NXT;
                    end else begin
                        n_h       = h_next;
                        o_rd_addr = h_next[AW-1:0];
                    end
                end
            end
            S_FREE_NXT: begin
                o_wr_en        = 1'b1;
                o_wr_data.used = 1'b0;
                o_wr_data.size = (n_live && blk_free) ? merged : r_hsize;
                n_res.success        = 1'b1;
                n_res.payload_offset = '0;
                n_state              = S_DONE;
            end
            S_SPLIT: begin
                // The request becomes a used block at the tail of the candidate.
                o_wr_en              = 1'b1;
                o_wr_addr            = r_nh;
                o_wr_data.used       = 1'b1;
                o_wr_data.size       = SIZE_W'(r_req);
                n_res.success        = 1'b1;
                n_res.payload_offset = CFG_W'(SW'(r_nh) + SW'(HEADER_BYTES));
                n_state              = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_eff   <= clamp_region(CFG_W'(CFG_RESET));
        end else begin
            r_state <= n_state;
            r_eff   <= n_eff;
        end
    end

    // Walk registers and the pending result.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_req       <= n_req;
        r_off       <= n_off;
        r_h         <= n_h;
        r_n         <= n_n;
        r_have      <= n_have;
        r_best      <= n_best;
        r_best_size <= n_best_size;
        r_hsize     <= n_hsize;
        r_nh        <= n_nh;
        r_res       <= n_res;
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);
    assign o_res            = r_res;

endmodule

// ===== rtl/core/bfba_checker.sv =====
`include "best_fit_block_allocator_macros.svh"

module bfba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input bfba_pkg::t_out_item         o_out,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready
);
    import bfba_pkg::*;

    // A stalled result stays put.
    `BFBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

    // An accepted item keeps the block busy in the following cycle.
    `BFBA_ASSERT_NEXT(a_busy_after_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A region write rebuilds the chain before anything else is taken.
    `BFBA_ASSERT_NEXT(a_init_after_cfg, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, o_in_stall && !o_cfg_ready)

    // A failed result carries a zero offset.
    `BFBA_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, o_out_valid && !o_out.success, o_out.payload_offset == '0)

endmodule

bind best_fit_block_allocator bfba_checker u_bfba_checker (.*);

// ===== tb/tb_best_fit_block_allocator.sv =====
`timescale 1ns / 1ps

// Tracks the block chain of the allocator and holds the outcome that each
// accepted item must produce, oldest first.
class alloc_scoreboard #(int HDR = 4, int SPAN = 4096);

    // Header memory as the chain walk sees it, indexed by header offset.
    logic [15:0] size_mem [SPAN];
    bit          used_mem [SPAN];
    int unsigned region_len;

    bfba_pkg::t_out_item pending_outcomes [$];

    // Offsets that steer the stimulus toward valid frees and exact fits.
    int unsigned live_offsets  [$];
    int unsigned freed_offsets [$];
    int unsigned freed_sizes   [$];

    int errors;

    function new();
        errors = 0;
        set_region(bfba_pkg::CFG_RESET);
    endfunction

    // A region write saturates the size and lays down one free block.
    function void set_region(int unsigned val);
        int unsigned r;
        r = val;
        if (r < bfba_pkg::REGION_MIN) r = bfba_pkg::REGION_MIN;
        if (r > SPAN) r = SPAN;
        region_len = r;
        foreach (size_mem[i]) begin
            size_mem[i] = '0;
            used_mem[i] = 1'b0;
        end
        size_mem[0] = 16'(r - HDR);
        live_offsets.delete();
        freed_offsets.delete();
        freed_sizes.delete();
    endfunction

    function int unsigned next_header(int unsigned h);
        int unsigned n;
        n = h + HDR + size_mem[h % SPAN];
        return (n >= region_len) ? region_len : n;
    endfunction

    // Best-fit search: the first exact fit wins, else the smallest block that
    // leaves room for a new header is split and the request cut from its tail.
    function bfba_pkg::t_out_item grant_alloc(int unsigned req);
        bfba_pkg::t_out_item res;
        int unsigned h, best, sz, rest, nh;
        bit have;
        h = 0;
        best = 0;
        have = 1'b0;
        res = '0;
        while (h < region_len) begin
            sz = size_mem[h];
            if (!used_mem[h]) begin
                if (sz == req) begin
                    used_mem[h] = 1'b1;
                    res.success = 1'b1;
                    res.payload_offset = 13'(h + HDR);
                    return res;
                end
                if (req + HDR < sz && (!have || sz < size_mem[best])) begin
                    best = h;
                    have = 1'b1;
                end
            end
            h = next_header(h);
        end
        if (!have) return res;
        rest = size_mem[best] - (req + HDR);
        nh = (best + HDR + rest) % SPAN;
        size_mem[best] = 16'(rest);
        used_mem[nh] = 1'b1;
        size_mem[nh] = 16'(req);
        res.success = 1'b1;
        res.payload_offset = 13'(nh + HDR);
        return res;
    endfunction

    // A free clears the used flag and absorbs a free direct successor only.
    function bfba_pkg::t_out_item release_block(int unsigned off);
        bfba_pkg::t_out_item res;
        int unsigned h, n;
        res = '0;
        h = 0;
        while (h < region_len) begin
            if (h + HDR == off) begin
                n = next_header(h);
                freed_sizes.push_back(size_mem[h]);
                used_mem[h] = 1'b0;
                if (n < region_len && !used_mem[n])
                    size_mem[h] = 16'(size_mem[h] + HDR + size_mem[n]);
                foreach (live_offsets[i]) begin
                    if (live_offsets[i] == off) begin
                        live_offsets.delete(i);
                        break;
                    end
                end
                freed_offsets.push_back(off);
                res.success = 1'b1;
                return res;
            end
            h = next_header(h);
        end
        return res;
    endfunction

    function void note_request(bfba_pkg::t_in_item it);
        bfba_pkg::t_out_item res;
        if (it.opcode == bfba_pkg::OP_ALLOC) begin
            res = grant_alloc(it.request_size);
            if (res.success) live_offsets.push_back(res.payload_offset);
        end else if (it.free_is_null) begin
            res = '0;
            res.success = 1'b1;
        end else begin
            res = release_block(it.free_offset);
        end
        pending_outcomes.push_back(res);
    endfunction

    function void check_response(bfba_pkg::t_out_item got);
        bfba_pkg::t_out_item want;
        if (pending_outcomes.size() == 0) begin
            $error("unexpected result item: success %0d payload_offset %0d",
                   got.success, got.payload_offset);
            errors++;
            return;
        end
        want = pending_outcomes.pop_front();
        if (got.success !== want.success) begin
            $error("success: expected %0d, actual %0d", want.success, got.success);
            errors++;
        end
        if (got.payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %0d, actual %0d",
                   want.payload_offset, got.payload_offset);
            errors++;
        end
    endfunction

endclass

module tb_best_fit_block_allocator;
    import bfba_pkg::*;

    localparam int REGION_MAX     = 4096;
    localparam int HDR            = 4;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 72;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_item;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int quiet_cycles  = 0;

    alloc_scoreboard #(HDR, REGION_MAX) sb;

    best_fit_block_allocator #(
        .REGION_BYTES(REGION_MAX),
        .HEADER_BYTES(HDR)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: random stall, or a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Every accepted result item is checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_response(out_item);
    end

    // The run ends if no handshake of any kind completes for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Fields that the operation ignores still carry random bits.
    function automatic t_in_item alloc_item(int unsigned size);
        t_in_item it;
        it.opcode       = OP_ALLOC;
        it.request_size = CFG_W'(size);
        it.free_offset  = CFG_W'($urandom_range(0, 8191));
        it.free_is_null = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_in_item free_item(int unsigned off, bit is_null);
        t_in_item it;
        it.opcode       = OP_FREE;
        it.request_size = CFG_W'($urandom_range(0, 8191));
        it.free_offset  = CFG_W'(off);
        it.free_is_null = is_null;
        return it;
    endfunction

    // Mostly allocations and frees of live blocks, with exact-fit sizes,
    // repeated frees, null frees and stray offsets mixed in.
    function automatic t_in_item random_item();
        int unsigned pick, sel, size;
        pick = $urandom_range(0, 99);
        if (pick < 50 || (pick < 80 && sb.live_offsets.size() == 0)) begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                size = $urandom_range(0, 48);
            else if (sel < 85)
                size = $urandom_range(0, 400);
            else if (sel < 95 && sb.freed_sizes.size() > 0)
                size = sb.freed_sizes[$urandom_range(0, sb.freed_sizes.size() - 1)];
            else
                size = $urandom_range(0, 8191);
            return alloc_item(size);
        end
        if (pick < 80)
            return free_item(sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)],
                             1'b0);
        if (pick < 87 && sb.freed_offsets.size() > 0)
            return free_item(sb.freed_offsets[$urandom_range(0, sb.freed_offsets.size() - 1)],
                             1'b0);
        if (pick < 93)
            return free_item($urandom_range(0, 8191), 1'b1);
        if ($urandom_range(0, 1))
            return free_item($urandom_range(0, 8191), 1'b0);
        return free_item(4 * $urandom_range(0, 1024), 1'b0);
    endfunction

    // Offer one item, after a random gap, and hold it until it is taken.
    task automatic send_item(input t_in_item it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_request(it);
    endtask

    task automatic write_region(input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_region(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] region, input int send_pct,
                             input int stall, input bit pressure);
        write_region(region);
        send_idle_pct = send_pct;
        stall_pct = stall;
        if (pressure) hold_requests++;
        repeat (PHASE_ITEMS) send_item(random_item());
        wait_drained();
    endtask

    initial begin
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset region of 4096 bytes.
        send_item(free_item(8191, 1'b1));     // null free
        send_item(free_item(0, 1'b0));        // header offset is not a payload
        send_item(alloc_item(0));             // zero size split from the tail
        send_item(alloc_item(8191));          // far too large
        send_item(alloc_item(4096));
        send_item(alloc_item(100));
        send_item(alloc_item(100));
        send_item(free_item(4096, 1'b0));     // last block, no successor
        send_item(alloc_item(0));             // exact fit on a zero-size block
        send_item(free_item(3992, 1'b0));     // used successor, no merge
        send_item(free_item(3888, 1'b0));     // merges the free successor
        send_item(free_item(3888, 1'b0));     // free of a block already free
        send_item(alloc_item(204));           // exact fit beats a larger block
        send_item(free_item(3888, 1'b0));
        send_item(free_item(4096, 1'b0));
        send_item(free_item(3888, 1'b0));     // free block absorbs a free successor
        send_item(free_item(3891, 1'b0));     // misaligned offset
        send_item(free_item(0, 1'b1));
        send_item(alloc_item(203));           // smallest fitting block gets split
        send_item(alloc_item(1));
        send_item(alloc_item(3876));          // leaves no room for a header
        send_item(alloc_item(3875));
        send_item(alloc_item(1));
        send_item(alloc_item(0));             // nothing free is left
        send_item(free_item(9, 1'b0));
        wait_drained();

        // Random phases over several region sizes, saturated ones included.
        run_phase(13'd8191, 0, 0, 1'b0);
        run_phase(13'd0, 56, 0, 1'b0);
        run_phase(13'd1000, 0, 56, 1'b0);
        run_phase(13'd64, 33, 33, 1'b0);
        run_phase(13'd300, 0, 0, 1'b1);
        run_phase(13'd4096, 33, 33, 1'b0);

        if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
